/* sv/ptt_pkg.sv */
`default_nettype none

package ptt_pkg;

	// configuration register indexes
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 10;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_X      = 3'd0,
		REG_GAIN_Y      = 3'd1,
		REG_DEADZONE    = 3'd2,
		REG_SLOW_RADIUS = 3'd3,
		REG_MIN_ANGLE_X = 3'd4,
		REG_MAX_ANGLE_X = 3'd5,
		REG_MIN_ANGLE_Y = 3'd6,
		REG_MAX_ANGLE_Y = 3'd7
	} cfg_reg_t;

	// reset values
	localparam logic [9:0] GainReset     = 10'd26;
	localparam logic [7:0] DeadzoneReset = 8'd5;
	localparam logic [7:0] SlowReset     = 8'd10;
	localparam logic [7:0] MinAngleReset = 8'd0;
	localparam logic [7:0] MaxAngleReset = 8'd180;
	localparam logic [7:0] HeldReset     = 8'd90;

	// gain fraction bits
	localparam int unsigned FracBits = 8;

	// input item
	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [7:0] angle_x;
		logic [7:0] angle_y;
		logic       moved;
	} out_item_t;

	// what one axis lane found
	typedef struct packed {
		logic               over_dz;
		logic [15:0]        err_sq;
		logic signed [19:0] prod;
	} lane_res_t;

	// merged decision for both axes
	typedef struct packed {
		logic moved;
		logic slow;
	} decision_t;

endpackage

`default_nettype wire

/* sv/pan_tilt_proportional_tracker.sv */
`default_nettype none

// Pan/tilt proportional tracker. Takes one target pair per cycle and returns
// one result item per target, in the cycle after acceptance, from an output
// register. Each axis has its own lane (clamp, error, square, gain product);
// a merge stage forms the deadzone and slow zone decisions, and the new held
// angles are written at the same edge, so the next item already sees them.
// Sustained rate is one item per cycle unless the output stalls, set by the
// loop through the lanes back to the held angle registers; input stall is raised
// only while a finished result is stalled at the output. Configuration writes
// are always ready and should be made while no item is in flight.
module pan_tilt_proportional_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ptt_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ptt_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ptt_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [ptt_pkg::CfgDataW-1:0]    cfg_data
);

	logic [9:0]          gain_x_q, gain_y_q;
	logic [7:0]          deadzone_q, slow_radius_q;
	logic [7:0]          min_x_q, max_x_q, min_y_q, max_y_q;
	logic [7:0]          held_x_q, held_y_q;
	logic                out_valid_q;
	ptt_pkg::out_item_t  out_q;
	ptt_pkg::lane_res_t  res_x, res_y;
	ptt_pkg::decision_t  dec;
	logic [7:0]          next_x, next_y;
	logic                fire;

	// handshake
	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign fire      = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q      <= ptt_pkg::GainReset;
			gain_y_q      <= ptt_pkg::GainReset;
			deadzone_q    <= ptt_pkg::DeadzoneReset;
			slow_radius_q <= ptt_pkg::SlowReset;
			min_x_q       <= ptt_pkg::MinAngleReset;
			max_x_q       <= ptt_pkg::MaxAngleReset;
			min_y_q       <= ptt_pkg::MinAngleReset;
			max_y_q       <= ptt_pkg::MaxAngleReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ptt_pkg::cfg_reg_t'(cfg_index))
				ptt_pkg::REG_GAIN_X:      gain_x_q      <= cfg_data;
				ptt_pkg::REG_GAIN_Y:      gain_y_q      <= cfg_data;
				ptt_pkg::REG_DEADZONE:    deadzone_q    <= cfg_data[7:0];
				ptt_pkg::REG_SLOW_RADIUS: slow_radius_q <= cfg_data[7:0];
				ptt_pkg::REG_MIN_ANGLE_X: min_x_q       <= cfg_data[7:0];
				ptt_pkg::REG_MAX_ANGLE_X: max_x_q       <= cfg_data[7:0];
				ptt_pkg::REG_MIN_ANGLE_Y: min_y_q       <= cfg_data[7:0];
				ptt_pkg::REG_MAX_ANGLE_Y: max_y_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// axis lanes
	ptt_lane u_lane_x (
		.target   (in_data.target_x),
		.held     (held_x_q),
		.lo       (min_x_q),
		.hi       (max_x_q),
		.deadzone (deadzone_q),
		.gain     (gain_x_q),
		.res      (res_x)
	);

	ptt_lane u_lane_y (
		.target   (in_data.target_y),
		.held     (held_y_q),
		.lo       (min_y_q),
		.hi       (max_y_q),
		.deadzone (deadzone_q),
		.gain     (gain_y_q),
		.res      (res_y)
	);

	// merge lane findings
	ptt_merge u_merge (
		.res_x       (res_x),
		.res_y       (res_y),
		.slow_radius (slow_radius_q),
		.dec         (dec)
	);

	// per-axis update
	ptt_apply u_apply_x (
		.prod       (res_x.prod),
		.held       (held_x_q),
		.lo         (min_x_q),
		.hi         (max_x_q),
		.dec        (dec),
		.next_angle (next_x)
	);

	ptt_apply u_apply_y (
		.prod       (res_y.prod),
		.held       (held_y_q),
		.lo         (min_y_q),
		.hi         (max_y_q),
		.dec        (dec),
		.next_angle (next_y)
	);

	// held angles and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= ptt_pkg::HeldReset;
			held_y_q    <= ptt_pkg::HeldReset;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				held_x_q    <= next_x;
				held_y_q    <= next_y;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result item register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.angle_x <= next_x;
			out_q.angle_y <= next_y;
			out_q.moved   <= dec.moved;
		end
	end

	// checks
	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("accepted item produced no result");

	a_result_matches_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.angle_x == held_x_q) && (out_data.angle_y == held_y_q))
		else $error("pending result disagrees with held angles");

	a_held_only_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(held_x_q) && $stable(held_y_q))
		else $error("held angles changed without an item");

endmodule

`default_nettype wire

/* sv/ptt_lane.sv */
`default_nettype none

module ptt_lane (
	input  logic signed [15:0] target,
	input  logic [7:0]         held,
	input  logic [7:0]         lo,
	input  logic [7:0]         hi,
	input  logic [7:0]         deadzone,
	input  logic [9:0]         gain,
	output ptt_pkg::lane_res_t res
);

	logic [7:0]        tgt;
	logic signed [8:0] err;
	logic [8:0]        abs_err;

	// clamp target, min tested first
	always_comb begin
		if (target < $signed({8'd0, lo})) begin
			tgt = lo;
		end else if (target > $signed({8'd0, hi})) begin
			tgt = hi;
		end else begin
			tgt = target[7:0];
		end
	end

	// error against held angle
	assign err     = $signed({1'b0, tgt}) - $signed({1'b0, held});
	assign abs_err = err[8] ? 9'(-err) : 9'(err);

	// deadzone test, squared error and gain product
	assign res.over_dz = abs_err > {1'b0, deadzone};
	assign res.err_sq  = {8'd0, abs_err[7:0]} * {8'd0, abs_err[7:0]};
	assign res.prod    = $signed({10'd0, gain}) * $signed({{11{err[8]}}, err});

endmodule

`default_nettype wire

/* sv/ptt_merge.sv */
`default_nettype none

module ptt_merge (
	input  ptt_pkg::lane_res_t res_x,
	input  ptt_pkg::lane_res_t res_y,
	input  logic [7:0]         slow_radius,
	output ptt_pkg::decision_t dec
);

	logic [16:0] dist2;
	logic [15:0] r2;

	// combine both lanes
	assign dist2     = {1'b0, res_x.err_sq} + {1'b0, res_y.err_sq};
	assign r2        = {8'd0, slow_radius} * {8'd0, slow_radius};
	assign dec.moved = res_x.over_dz || res_y.over_dz;
	assign dec.slow  = dist2 < {1'b0, r2};

endmodule

`default_nettype wire

/* sv/ptt_apply.sv */
`default_nettype none

module ptt_apply (
	input  logic signed [19:0] prod,
	input  logic [7:0]         held,
	input  logic [7:0]         lo,
	input  logic [7:0]         hi,
	input  ptt_pkg::decision_t dec,
	output logic [7:0]         next_angle
);

	logic signed [12:0] shifted;
	logic signed [12:0] sum;
	logic [7:0]         clamped;

	// floor division by 256, or 512 in the slow zone
	assign shifted = dec.slow ? 13'(prod >>> (ptt_pkg::FracBits + 1))
		: 13'(prod >>> ptt_pkg::FracBits);
	assign sum     = $signed({5'd0, held}) + shifted;

	// clamp new angle, min tested first
	always_comb begin
		if (sum < $signed({5'd0, lo})) begin
			clamped = lo;
		end else if (sum > $signed({5'd0, hi})) begin
			clamped = hi;
		end else begin
			clamped = sum[7:0];
		end
	end

	assign next_angle = dec.moved ? clamped : held;

endmodule

`default_nettype wire

/* dv/pan_tilt_proportional_tracker_tb.sv */
`timescale 1ns / 1ps

module pan_tilt_proportional_tracker_tb;

	import ptt_pkg::*;

	// how the two sides idle during a phase
	typedef enum int {
		MIX_RX_SLOW,
		MIX_TX_SLOW,
		MIX_NONE
	} idle_mix_t;

	localparam int QuietLimit = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	// tracker state and register copies, as after reset
	logic [7:0] held_x = HeldReset;
	logic [7:0] held_y = HeldReset;
	logic [9:0] kx = GainReset;
	logic [9:0] ky = GainReset;
	logic [7:0] dz = DeadzoneReset;
	logic [7:0] slow_r = SlowReset;
	logic [7:0] lo_x = MinAngleReset;
	logic [7:0] hi_x = MaxAngleReset;
	logic [7:0] lo_y = MinAngleReset;
	logic [7:0] hi_y = MaxAngleReset;

	in_item_t pending_targets[$];
	out_item_t expected_angles[$];
	idle_mix_t idle_mode = MIX_RX_SLOW;
	int mismatches = 0;
	int quiet_cycles = 0;

	pan_tilt_proportional_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// clamp test order: below low first, then above high
	function automatic int clamp_deg(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// one tracking step: new held angles and whether they moved
	function automatic out_item_t track_targets(in_item_t t);
		int tx, ty, ex, ey, dx, dy, shift_n;
		out_item_t r;
		tx = clamp_deg($signed(t.target_x), lo_x, hi_x);
		ty = clamp_deg($signed(t.target_y), lo_y, hi_y);
		ex = tx - int'(held_x);
		ey = ty - int'(held_y);
		r.moved = ((ex < 0 ? -ex : ex) > int'(dz)) || ((ey < 0 ? -ey : ey) > int'(dz));
		if (r.moved) begin
			// slow zone halves the correction
			if (ex * ex + ey * ey < int'(slow_r) * int'(slow_r))
				shift_n = FracBits + 1;
			else
				shift_n = FracBits;
			// arithmetic shift floors negative products
			dx = (int'(kx) * ex) >>> shift_n;
			dy = (int'(ky) * ey) >>> shift_n;
			held_x = 8'(clamp_deg(int'(held_x) + dx, lo_x, hi_x));
			held_y = 8'(clamp_deg(int'(held_y) + dy, lo_y, hi_y));
		end
		r.angle_x = held_x;
		r.angle_y = held_y;
		return r;
	endfunction

	function automatic bit roll_pct(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// mostly near the held angle, some across the limits, some anywhere
	function automatic int pick_target(logic [7:0] near);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 2)
			return int'($urandom_range(0, 65535)) - 32768;
		if (roll < 5)
			return int'($urandom_range(0, 196)) - 8;
		return int'(near) + int'($urandom_range(0, 30)) - 15;
	endfunction

	// register value for a random phase, extremes and raw 10 bit data included
	function automatic logic [9:0] pick_setting(cfg_reg_t r);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		case (r) inside
			REG_GAIN_X, REG_GAIN_Y: begin
				if (roll == 0)
					return 10'd0;
				if (roll == 1)
					return 10'd1023;
				if (roll < 6)
					return 10'($urandom_range(8, 80));
				return 10'($urandom_range(0, 1023));
			end
			REG_DEADZONE: begin
				if (roll == 0)
					return 10'd0;
				if (roll == 1)
					return 10'($urandom_range(180, 1023));
				return 10'($urandom_range(0, 12));
			end
			REG_SLOW_RADIUS: begin
				if (roll == 0)
					return 10'd0;
				if (roll == 1)
					return 10'd255;
				if (roll < 7)
					return 10'($urandom_range(0, 40));
				return 10'($urandom_range(0, 1023));
			end
			REG_MIN_ANGLE_X, REG_MIN_ANGLE_Y: begin
				if (roll == 0)
					return 10'd0;
				if (roll == 1)
					return 10'($urandom_range(0, 1023));
				return 10'($urandom_range(0, 60));
			end
			default: begin
				if (roll == 0)
					return 10'd180;
				if (roll == 1)
					return 10'($urandom_range(0, 1023));
				return 10'($urandom_range(120, 180));
			end
		endcase
	endfunction

	task automatic queue_target(int x, int y);
		in_item_t t;
		t.target_x = 16'(x);
		t.target_y = 16'(y);
		pending_targets.push_back(t);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [9:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// block idle: nothing queued, nothing presented, no result outstanding
	task automatic wait_idle();
		while (pending_targets.size() != 0 || in_valid || expected_angles.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// driver: present the next pending item, hold it while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_angles.push_back(track_targets(in_data));
			if (!in_valid || !in_stall) begin
				if (pending_targets.size() != 0 && !roll_pct(idle_mode == MIX_RX_SLOW ? 11 :
						idle_mode == MIX_TX_SLOW ? 77 : 0)) begin
					in_valid <= 1'b1;
					in_data <= pending_targets.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin : compare
				out_item_t want;
				if (expected_angles.size() == 0) begin
					$error("result with no item outstanding: angle_x %0d angle_y %0d moved %0d",
						out_data.angle_x, out_data.angle_y, out_data.moved);
					mismatches++;
				end else begin
					want = expected_angles.pop_front();
					check_field("angle_x", want.angle_x, out_data.angle_x);
					check_field("angle_y", want.angle_y, out_data.angle_y);
					check_field("moved", want.moved, out_data.moved);
				end
			end
			out_stall <= roll_pct(idle_mode == MIX_RX_SLOW ? 77 :
				idle_mode == MIX_TX_SLOW ? 11 : 0);
		end
	end

	// register copies follow each accepted write
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_X: kx <= cfg_data;
				REG_GAIN_Y: ky <= cfg_data;
				REG_DEADZONE: dz <= cfg_data[7:0];
				REG_SLOW_RADIUS: slow_r <= cfg_data[7:0];
				REG_MIN_ANGLE_X: lo_x <= cfg_data[7:0];
				REG_MAX_ANGLE_X: hi_x <= cfg_data[7:0];
				REG_MIN_ANGLE_Y: lo_y <= cfg_data[7:0];
				REG_MAX_ANGLE_Y: hi_y <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QuietLimit) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int seg, k, i;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: deadzone edges, slow zone, floor of negative steps, clamps
		queue_target(90, 90);
		queue_target(95, 85);
		queue_target(96, 90);
		queue_target(100, 90);
		queue_target(81, 91);
		queue_target(-32768, 32767);
		queue_target(32767, -32768);
		queue_target(0, 0);
		queue_target(180, 180);
		queue_target(181, -1);
		wait_idle();

		// full gain, no deadzone, widest slow zone, raw data truncated to 8 bits
		write_reg(REG_GAIN_X, 10'd1023);
		write_reg(REG_GAIN_Y, 10'd1023);
		write_reg(REG_DEADZONE, 10'd0);
		write_reg(REG_SLOW_RADIUS, 10'd255);
		write_reg(REG_MIN_ANGLE_X, 10'd0);
		write_reg(REG_MAX_ANGLE_X, 10'h3FF);
		write_reg(REG_MIN_ANGLE_Y, 10'd0);
		write_reg(REG_MAX_ANGLE_Y, 10'd180);
		queue_target(255, 0);
		queue_target(-1, 200);
		queue_target(300, 90);
		queue_target(0, 0);
		queue_target(128, 128);
		queue_target(129, 127);
		wait_idle();

		// zero gain on x, no slow zone, limits crossed over on both axes
		write_reg(REG_GAIN_X, 10'd0);
		write_reg(REG_GAIN_Y, 10'd512);
		write_reg(REG_SLOW_RADIUS, 10'd0);
		write_reg(REG_MIN_ANGLE_X, 10'd150);
		write_reg(REG_MAX_ANGLE_X, 10'd30);
		write_reg(REG_MIN_ANGLE_Y, 10'h3C8);
		write_reg(REG_MAX_ANGLE_Y, 10'd10);
		queue_target(0, 0);
		queue_target(100, 100);
		queue_target(200, 250);
		queue_target(32767, 32767);
		queue_target(-32768, -32768);
		queue_target(31, 9);

		// random phases, each with fresh settings
		for (seg = 0; seg < 8; seg++) begin
			wait_idle();
			if (seg < 3)
				idle_mode = MIX_RX_SLOW;
			else if (seg < 6)
				idle_mode = MIX_TX_SLOW;
			else
				idle_mode = MIX_NONE;
			for (i = 0; i < 8; i++)
				write_reg(cfg_reg_t'(i), pick_setting(cfg_reg_t'(i)));
			for (k = 0; k < 100; k++) begin
				while (pending_targets.size() >= 2)
					@(posedge clk);
				queue_target(pick_target(held_x), pick_target(held_y));
			end
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && expected_angles.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* pan_tilt_proportional_tracker.f */
sv/ptt_pkg.sv
sv/ptt_lane.sv
sv/ptt_merge.sv
sv/ptt_apply.sv
sv/pan_tilt_proportional_tracker.sv
dv/pan_tilt_proportional_tracker_tb.sv
